[sv/assert_macros.svh]
// Assertion macros used by the checker file of the turn tracker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must never hold at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

[sv/mftt_pkg.sv]
// Types and constants of the motor feedback turn tracker.
// Used by every module of the block; has no dependencies.
`default_nettype none

package mftt_pkg;

  // Configuration port geometry.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int SLOT_IDX_W = 6;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ID_BASE   = 2'd0;
  localparam logic [1:0] REG_WRAP_HIGH = 2'd1;
  localparam logic [1:0] REG_WRAP_LOW  = 2'd2;

  // Register reset values.
  localparam logic [10:0] ID_BASE_RST   = 11'd513;
  localparam logic [15:0] WRAP_HIGH_RST = 16'd7000;
  localparam logic [15:0] WRAP_LOW_RST  = 16'd1000;

  // Bus number that is not a real bus.
  localparam logic [1:0] BUS_NONE = 2'd3;

  typedef struct packed {
    logic [10:0] id_base;
    logic [15:0] wrap_high;
    logic [15:0] wrap_low;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  bus_select;
    logic [10:0] frame_id;
    logic        new_message;
    logic [55:0] frame_data;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot_index;
    logic               slot_valid;
    logic [15:0]        encoder_pos;
    logic signed [15:0] rotor_speed;
    logic signed [15:0] motor_current;
    logic [7:0]         temperature;
    logic signed [31:0] turn_count;
  } result_t;

  // One table entry: last encoder value and multi-turn count.
  typedef struct packed {
    logic [15:0] last_enc;
    logic [31:0] turn_acc;
  } entry_t;

  // Read-modify-write traffic towards the table.
  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_idx;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_idx;
    entry_t                wr_data;
  } tbl_req_t;

endpackage

`default_nettype wire

[sv/mftt_regs.sv]
// APB-style configuration registers of the turn tracker.
// Depends on mftt_pkg.
`default_nettype none

module mftt_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mftt_pkg::PADDR_W-1:0] paddr,
  input  logic [mftt_pkg::PDATA_W-1:0] pwdata,
  output logic [mftt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output mftt_pkg::cfg_t               cfg_o
);
  import mftt_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write decode; an address past the last register is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ID_BASE:   cfg_d.id_base   = pwdata[10:0];
        REG_WRAP_HIGH: cfg_d.wrap_high = pwdata[15:0];
        REG_WRAP_LOW:  cfg_d.wrap_low  = pwdata[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_base   <= ID_BASE_RST;
      cfg_q.wrap_high <= WRAP_HIGH_RST;
      cfg_q.wrap_low  <= WRAP_LOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      REG_ID_BASE:   prdata = {{(PDATA_W-11){1'b0}}, cfg_q.id_base};
      REG_WRAP_HIGH: prdata = {{(PDATA_W-16){1'b0}}, cfg_q.wrap_high};
      REG_WRAP_LOW:  prdata = {{(PDATA_W-16){1'b0}}, cfg_q.wrap_low};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/mftt_slot_calc.sv]
// Slot computation: bus times stride plus identifier minus base, and range check.
// Depends on mftt_pkg.
`default_nettype none

module mftt_slot_calc #(
  parameter int MOTOR_SLOTS = 33,
  parameter int BUS_STRIDE  = 11,
  parameter int SLOT_W      = 13
) (
  input  logic [1:0]               bus_select_i,
  input  logic [10:0]              frame_id_i,
  input  logic [10:0]              id_base_i,
  output logic signed [SLOT_W-1:0] slot_o,
  output logic                     in_range_o
);
  import mftt_pkg::*;

  logic signed [SLOT_W-1:0] bus_off;
  logic signed [SLOT_W-1:0] id_ext;
  logic signed [SLOT_W-1:0] base_ext;

  // Small constant product, then one add and one subtract.
  assign bus_off  = $signed(SLOT_W'(bus_select_i)) * $signed(SLOT_W'(BUS_STRIDE));
  assign id_ext   = $signed(SLOT_W'(frame_id_i));
  assign base_ext = $signed(SLOT_W'(id_base_i));
  assign slot_o   = bus_off + id_ext - base_ext;

  // Inside the table only for a real bus and 0 <= slot < MOTOR_SLOTS.
  assign in_range_o = (bus_select_i != BUS_NONE) && !slot_o[SLOT_W-1] &&
                      ($unsigned(slot_o) < SLOT_W'(MOTOR_SLOTS));

endmodule

`default_nettype wire

[sv/mftt_track_mem.sv]
// Per-slot table of last encoder value and turn count, with a registered read port.
// Depends on mftt_pkg.
`default_nettype none

module mftt_track_mem #(
  parameter int MOTOR_SLOTS = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mftt_pkg::tbl_req_t req_i,
  output mftt_pkg::entry_t   rd_data_o
);
  import mftt_pkg::*;

  localparam int IdxW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

  entry_t                 mem [MOTOR_SLOTS];
  entry_t                 rd_q;
  logic [MOTOR_SLOTS-1:0] vld_q;
  logic                   rd_vld_q;
  logic [IdxW-1:0]        rd_idx;
  logic [IdxW-1:0]        wr_idx;

  assign rd_idx = req_i.rd_idx[IdxW-1:0];
  assign wr_idx = req_i.wr_idx[IdxW-1:0];

  // Storage array: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_idx] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  // Valid bits stand for the all-zero reset contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[rd_idx];
      end
    end
  end

  // An entry never written reads as zero.
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

[sv/motor_feedback_turn_tracker_top.sv]
// Top level of the motor feedback turn tracker: control, decode and count update.
// Depends on mftt_pkg, mftt_regs, mftt_slot_calc and mftt_track_mem.
//
//   Channel   Signals                              Transfer when
//   frame     start, busy, item_i                  start && !busy
//   result    result_valid_o, result_o             result_valid_o (one cycle)
//   config    psel, penable, pwrite, paddr, pwdata psel && penable && pwrite
//
// Per frame, the table is read at the accepting edge and the updated entry is
// written back at the next edge, so busy is high for one cycle.
// The result strobe rises at the write-back edge and is taken at the edge after
// it, the earliest next accept. Frames without the new-message flag give no strobe.
// Reset clears state, strobe and table valid bits at once; no clearing pass.
// The receiver cannot stall; results are never held.
`default_nettype none

module motor_feedback_turn_tracker_top #(
  parameter int MOTOR_SLOTS        = 33,
  parameter int ENCODER_FULL_SCALE = 8192,
  parameter int BUS_STRIDE         = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  mftt_pkg::in_item_t           item_i,
  output logic                         result_valid_o,
  output mftt_pkg::result_t            result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mftt_pkg::PADDR_W-1:0] paddr,
  input  logic [mftt_pkg::PDATA_W-1:0] pwdata,
  output logic [mftt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import mftt_pkg::*;

  localparam int SlotW = $clog2(3 * BUS_STRIDE + 2048) + 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  cfg_t                    cfg;
  tbl_req_t                req;
  entry_t                  rd_entry;
  logic signed [SlotW-1:0] slot;
  logic                    in_range;
  logic                    accept;

  logic                    state_q, state_d;
  in_item_t                item_q;
  logic signed [SlotW-1:0] slot_q;
  logic                    in_range_q;
  logic                    res_vld_q, res_vld_d;
  result_t                 res_q, res_d;

  logic [15:0] enc_now;
  logic [31:0] now32, prev32, full32;
  logic [31:0] new_count;
  logic        do_write;

  mftt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mftt_slot_calc #(
    .MOTOR_SLOTS (MOTOR_SLOTS),
    .BUS_STRIDE  (BUS_STRIDE),
    .SLOT_W      (SlotW)
  ) u_slot (
    .bus_select_i (item_i.bus_select),
    .frame_id_i   (item_i.frame_id),
    .id_base_i    (cfg.id_base),
    .slot_o       (slot),
    .in_range_o   (in_range)
  );

  mftt_track_mem #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_entry)
  );

  assign busy   = (state_q == ST_UPD);
  assign accept = start && !busy;

  // Sequencer: accept and read, then update and write back.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Frame capture at the accepting edge.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= item_i;
      slot_q     <= slot;
      in_range_q <= in_range;
    end
    res_q <= res_d;
  end

  // Multi-turn update from the entry just read.
  assign enc_now  = item_q.frame_data[55:40];
  assign now32    = {16'd0, enc_now};
  assign prev32   = {16'd0, rd_entry.last_enc};
  assign full32   = 32'(ENCODER_FULL_SCALE);
  assign do_write = busy && item_q.new_message && in_range_q;

  always_comb begin
    if (rd_entry.last_enc > cfg.wrap_high && enc_now < cfg.wrap_low) begin
      new_count = rd_entry.turn_acc + ((full32 - prev32) + now32);
    end else if (rd_entry.last_enc < cfg.wrap_low && enc_now > cfg.wrap_high) begin
      new_count = rd_entry.turn_acc - ((full32 - now32) + prev32);
    end else begin
      new_count = rd_entry.turn_acc + (now32 - prev32);
    end
  end

  // Table traffic. The write lands before the next frame can read, so no
  // forwarding is needed.
  always_comb begin
    req.rd_en            = accept && in_range;
    req.rd_idx           = in_range ? slot[SLOT_IDX_W-1:0] : '0;
    req.wr_en            = do_write;
    req.wr_idx           = slot_q[SLOT_IDX_W-1:0];
    req.wr_data.last_enc = enc_now;
    req.wr_data.turn_acc = new_count;
  end

  // Result formation.
  always_comb begin
    res_vld_d              = busy && item_q.new_message;
    res_d.slot_index       = slot_q[SLOT_IDX_W-1:0];
    res_d.slot_valid       = in_range_q;
    res_d.encoder_pos      = enc_now;
    res_d.rotor_speed      = $signed(item_q.frame_data[39:24]);
    res_d.motor_current    = $signed(item_q.frame_data[23:8]);
    res_d.temperature      = item_q.frame_data[7:0];
    res_d.turn_count       = in_range_q ? $signed(new_count) : '0;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

[sv/mftt_checker.sv]
// Port-level checks of the turn tracker, bound to its top level.
// Depends on mftt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mftt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input mftt_pkg::result_t result_o
);
  import mftt_pkg::*;

  // An accepted frame always occupies the update cycle.
  `ASSERT_CLK(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept without busy")

  // The update cycle lasts exactly one cycle.
  `ASSERT_CLK(a_busy_once, clk_i, rst_ni, busy |=> !busy, "busy held too long")

  // A result follows an update cycle and never overlaps one.
  `ASSERT_CLK(a_res_after, clk_i, rst_ni, result_valid_o |-> ($past(busy) && !busy), "stray result")

  // A frame outside the table reports a zero count.
  `ASSERT_NEVER(a_res_zero, clk_i, rst_ni,
    result_valid_o && !result_o.slot_valid && (result_o.turn_count != 0), "count on bad slot")

endmodule

bind motor_feedback_turn_tracker_top mftt_checker u_checker (.*);

`default_nettype wire
